// ----- src/http_header_line_parser_assert.svh -----
// Assertion macros shared by the header line parser modules.
// Each macro expects clk and rst_n to be in scope at the point of use.
`ifndef HTTP_HEADER_LINE_PARSER_ASSERT_SVH
`define HTTP_HEADER_LINE_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HHLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HHLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hhlp_pkg.sv -----
// Types, codes and constants of the HTTP header line parser.
// Used by every module of the block; depends on nothing.
package hhlp_pkg;

    // Width of the key and value byte counter.
    localparam int CNT_BITS = 11;
    localparam int LIMIT_BITS = 10;
    localparam int LEN_BITS = 11;
    localparam int CMP_BITS = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

    // The counter saturates at the lesser of 1024 and its own maximum.
    localparam int CNT_MAX_INT = (1 << CNT_BITS) - 1;
    localparam int LEN_CAP_INT = (CNT_MAX_INT < 1024) ? CNT_MAX_INT : 1024;
    localparam logic [CNT_BITS-1:0] LEN_CAP = CNT_BITS'(LEN_CAP_INT);
    localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(255);

    // Characters of interest.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Parser states.
    localparam logic [3:0] PS_START = 4'd0;
    localparam logic [3:0] PS_KEY = 4'd1;
    localparam logic [3:0] PS_COLON = 4'd2;
    localparam logic [3:0] PS_FIRSTVAL = 4'd3;
    localparam logic [3:0] PS_VALUE = 4'd4;
    localparam logic [3:0] PS_CR = 4'd5;
    localparam logic [3:0] PS_LF = 4'd6;
    localparam logic [3:0] PS_END_CR = 4'd7;
    localparam logic [3:0] PS_DONE = 4'd8;

    // Byte classes.
    localparam logic [2:0] CL_SKIP = 3'd0;
    localparam logic [2:0] CL_KEY = 3'd1;
    localparam logic [2:0] CL_SEP = 3'd2;
    localparam logic [2:0] CL_VAL = 3'd3;
    localparam logic [2:0] CL_EOL = 3'd4;
    localparam logic [2:0] CL_BLANK = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    // Error kinds.
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_KEY_EOL = 3'd1;
    localparam logic [2:0] ERR_NO_SPACE = 3'd2;
    localparam logic [2:0] ERR_VAL_LONG = 3'd3;
    localparam logic [2:0] ERR_CR_NO_LF = 3'd4;

    // Input mode.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          byte_class;
        logic [LEN_BITS-1:0] field_length;
        logic [1:0]          status;
        logic [2:0]          error_kind;
    } out_item_t;

    // Saturating increment of the byte counter.
    function automatic logic [CNT_BITS-1:0] count_up(input logic [CNT_BITS-1:0] c);
        logic [CNT_BITS-1:0] r;
        r = (c < LEN_CAP) ? c + CNT_ONE : LEN_CAP;
        return r;
    endfunction

endpackage

// ----- src/http_header_line_parser.sv -----
// Top level of the HTTP header line parser.
// Depends on hhlp_pkg, hhlp_parse and hhlp_out_buf.

// Classifies the bytes of an HTTP header section, one byte per cycle. Each
// accepted transfer on the input gives exactly one result transfer, which
// enters the output register, or the skid register if the output is stalled.
// The parser state machine and its single byte counter settle at once, so the
// block sustains one byte per clock. A two-entry output buffer holds results
// while the output is stalled; the input stalls only when both entries are
// occupied. Send a transfer with mode set to restart before each header block;
// the value limit register keeps its value across restarts and should only be
// written while no results are outstanding.
module http_header_line_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  hhlp_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output hhlp_pkg::out_item_t                out_data,
    input  logic                               cfg_we,
    input  logic [hhlp_pkg::LIMIT_BITS-1:0]    cfg_wdata
);

    logic                 in_fire;
    logic                 buf_full;
    hhlp_pkg::out_item_t  result;

    // An input transfer completes whenever the buffer has room.
    assign in_stall = buf_full;
    assign in_fire = in_valid && !buf_full;

    hhlp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (in_fire),
        .item      (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    hhlp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .load_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- src/hhlp_parse.sv -----
// Per-byte parser state machine, byte counter, sticky error and limit register.
// Depends on hhlp_pkg and the shared assertion macros.
`include "http_header_line_parser_assert.svh"

module hhlp_parse (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  hhlp_pkg::in_item_t                 item,
    input  logic                               cfg_we,
    input  logic [hhlp_pkg::LIMIT_BITS-1:0]    cfg_wdata,
    output hhlp_pkg::out_item_t                result
);

    logic [3:0]                       state_reg;
    logic [3:0]                       state_next;
    logic [hhlp_pkg::CNT_BITS-1:0]    cnt_reg;
    logic [hhlp_pkg::CNT_BITS-1:0]    cnt_next;
    logic [2:0]                       err_reg;
    logic [2:0]                       err_next;
    logic [hhlp_pkg::LIMIT_BITS-1:0]  limit_reg;
    logic [2:0]                       err_new;
    logic                             over_limit;
    logic                             restart_fire;
    logic                             held_error_fire;
    logic                             parse_clear;

    // A value byte is too long once the count has passed the limit.
    assign over_limit = hhlp_pkg::CMP_BITS'(cnt_reg) > hhlp_pkg::CMP_BITS'(limit_reg);

    // Next state and result for the byte on offer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        err_new = hhlp_pkg::ERR_NONE;
        result.byte_class = hhlp_pkg::CL_SKIP;
        result.field_length = '0;
        result.status = hhlp_pkg::ST_BUSY;
        result.error_kind = hhlp_pkg::ERR_NONE;

        if (item.mode == hhlp_pkg::MODE_RESTART)
        begin
            state_next = hhlp_pkg::PS_START;
            cnt_next = '0;
            err_next = hhlp_pkg::ERR_NONE;
        end
        else if (err_reg == hhlp_pkg::ERR_NONE)
        begin
            unique case (state_reg)
                hhlp_pkg::PS_KEY:
                begin
                    if (item.data_byte == hhlp_pkg::CH_COLON)
                    begin
                        result.byte_class = hhlp_pkg::CL_SEP;
                        result.field_length = hhlp_pkg::LEN_BITS'(cnt_reg);
                        state_next = hhlp_pkg::PS_COLON;
                    end
                    else if (item.data_byte == hhlp_pkg::CH_CR ||
                             item.data_byte == hhlp_pkg::CH_LF)
                    begin
                        err_new = hhlp_pkg::ERR_KEY_EOL;
                    end
                    else
                    begin
                        result.byte_class = hhlp_pkg::CL_KEY;
                        cnt_next = hhlp_pkg::count_up(cnt_reg);
                    end
                end
                hhlp_pkg::PS_COLON:
                begin
                    if (item.data_byte == hhlp_pkg::CH_SPACE)
                    begin
                        result.byte_class = hhlp_pkg::CL_SEP;
                        state_next = hhlp_pkg::PS_FIRSTVAL;
                    end
                    else
                    begin
                        err_new = hhlp_pkg::ERR_NO_SPACE;
                    end
                end
                hhlp_pkg::PS_FIRSTVAL:
                begin
                    result.byte_class = hhlp_pkg::CL_VAL;
                    cnt_next = hhlp_pkg::CNT_ONE;
                    state_next = hhlp_pkg::PS_VALUE;
                end
                hhlp_pkg::PS_VALUE:
                begin
                    if (item.data_byte == hhlp_pkg::CH_CR)
                    begin
                        result.byte_class = hhlp_pkg::CL_EOL;
                        result.field_length = hhlp_pkg::LEN_BITS'(cnt_reg);
                        state_next = hhlp_pkg::PS_CR;
                    end
                    else if (over_limit)
                    begin
                        err_new = hhlp_pkg::ERR_VAL_LONG;
                    end
                    else
                    begin
                        result.byte_class = hhlp_pkg::CL_VAL;
                        cnt_next = hhlp_pkg::count_up(cnt_reg);
                    end
                end
                hhlp_pkg::PS_CR:
                begin
                    if (item.data_byte == hhlp_pkg::CH_LF)
                    begin
                        result.byte_class = hhlp_pkg::CL_EOL;
                        state_next = hhlp_pkg::PS_LF;
                    end
                    else
                    begin
                        err_new = hhlp_pkg::ERR_CR_NO_LF;
                    end
                end
                hhlp_pkg::PS_LF:
                begin
                    if (item.data_byte == hhlp_pkg::CH_CR)
                    begin
                        result.byte_class = hhlp_pkg::CL_BLANK;
                        state_next = hhlp_pkg::PS_END_CR;
                    end
                    else
                    begin
                        result.byte_class = hhlp_pkg::CL_KEY;
                        cnt_next = hhlp_pkg::CNT_ONE;
                        state_next = hhlp_pkg::PS_KEY;
                    end
                end
                hhlp_pkg::PS_END_CR:
                begin
                    if (item.data_byte == hhlp_pkg::CH_LF)
                    begin
                        result.byte_class = hhlp_pkg::CL_BLANK;
                        result.status = hhlp_pkg::ST_DONE;
                        state_next = hhlp_pkg::PS_DONE;
                    end
                    else
                    begin
                        err_new = hhlp_pkg::ERR_CR_NO_LF;
                    end
                end
                hhlp_pkg::PS_DONE:
                begin
                    result.status = hhlp_pkg::ST_DONE;
                end
                default:
                begin
                    // Line start, and any unused code: leading CR and LF are skipped.
                    if (item.data_byte != hhlp_pkg::CH_CR &&
                        item.data_byte != hhlp_pkg::CH_LF)
                    begin
                        result.byte_class = hhlp_pkg::CL_KEY;
                        cnt_next = hhlp_pkg::CNT_ONE;
                        state_next = hhlp_pkg::PS_KEY;
                    end
                    else
                    begin
                        state_next = hhlp_pkg::PS_START;
                    end
                end
            endcase

            if (err_new != hhlp_pkg::ERR_NONE)
            begin
                err_next = err_new;
            end
        end

        // Once an error is latched every byte reports it and nothing else.
        if (item.mode == hhlp_pkg::MODE_BYTE && err_next != hhlp_pkg::ERR_NONE)
        begin
            result.byte_class = hhlp_pkg::CL_SKIP;
            result.field_length = '0;
            result.status = hhlp_pkg::ST_ERR;
            result.error_kind = err_next;
        end
    end

    // Parser state advances on each accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hhlp_pkg::PS_START;
            cnt_reg <= '0;
            err_reg <= hhlp_pkg::ERR_NONE;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    // Value length limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= hhlp_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Terms for the checks below.
    assign restart_fire = fire && item.mode == hhlp_pkg::MODE_RESTART;
    assign held_error_fire = fire && item.mode == hhlp_pkg::MODE_BYTE &&
                             err_reg != hhlp_pkg::ERR_NONE;
    assign parse_clear = state_reg == hhlp_pkg::PS_START && cnt_reg == '0 &&
                         err_reg == hhlp_pkg::ERR_NONE;

    `HHLP_ASSERT_NEXT(a_restart_clears, restart_fire, parse_clear, "restart did not clear")
    `HHLP_ASSERT_NEXT(a_error_sticky, held_error_fire, $stable(err_reg) && $stable(state_reg), "error changed")
    `HHLP_ASSERT_NOW(a_count_capped, 1'b1, cnt_reg <= hhlp_pkg::LEN_CAP, "byte counter passed its cap")

endmodule

// ----- src/hhlp_out_buf.sv -----
// Two-entry result buffer: an output register with a skid register behind it.
// Depends on hhlp_pkg and the shared assertion macros.
`include "http_header_line_parser_assert.svh"

module hhlp_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  hhlp_pkg::out_item_t  load_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output hhlp_pkg::out_item_t  out_data
);

    logic                 main_valid_reg;
    hhlp_pkg::out_item_t  main_data_reg;
    logic                 skid_valid_reg;
    hhlp_pkg::out_item_t  skid_data_reg;
    logic                 main_free;

    // The output register can take a new result when empty or being drained.
    assign main_free = !main_valid_reg || !out_stall;
    assign full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data = main_data_reg;

    // Valid flags of both entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || load;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of both entries; the skid entry is drained first.
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : load_data;
        end
        else if (load)
        begin
            skid_data_reg <= load_data;
        end
    end

    `HHLP_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid entry held with empty output register")
    `HHLP_ASSERT_NEXT(a_skid_drains, skid_valid_reg && !out_stall, !skid_valid_reg && main_valid_reg, "skid entry not moved on drain")

endmodule
